// File: src/mpeg1_video_header_parser_core_defines.svh
// Assertion macros used by the checker file.
`ifndef MPEG1_VIDEO_HEADER_PARSER_CORE_DEFINES_SVH
`define MPEG1_VIDEO_HEADER_PARSER_CORE_DEFINES_SVH

// Same-cycle implication.
`define MVHP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define MVHP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/mvhp_pkg.sv
// ----------------------------------------------------------------------------
// MPEG-1 header parser package
// Phase codes, event codes, queue entry type and the constant tables.
// ----------------------------------------------------------------------------
`default_nettype none

package mvhp_pkg;

    typedef enum logic [13:0] {
        PH_HUNT  = 14'b00000000000001,
        PH_CODE  = 14'b00000000000010,
        PH_SIZES = 14'b00000000000100,
        PH_SSKIP = 14'b00000000001000,
        PH_IFLAG = 14'b00000000010000,
        PH_IMAT  = 14'b00000000100000,
        PH_NFLAG = 14'b00000001000000,
        PH_NSKIP = 14'b00000010000000,
        PH_PIC   = 14'b00000100000000,
        PH_PSKIP = 14'b00001000000000,
        PH_XFLAG = 14'b00010000000000,
        PH_XSKIP = 14'b00100000000000,
        PH_SLICE = 14'b01000000000000,
        PH_DONE  = 14'b10000000000000
    } phase_t;

    localparam logic [2:0] EV_MATRIX = 3'd0;
    localparam logic [2:0] EV_SIZES  = 3'd1;
    localparam logic [2:0] EV_PIC    = 3'd2;
    localparam logic [2:0] EV_SLICE  = 3'd3;
    localparam logic [2:0] EV_END    = 3'd4;

    localparam logic [7:0] SC_SEQ_HDR   = 8'hB3;
    localparam logic [7:0] SC_PICTURE   = 8'h00;
    localparam logic [7:0] SC_SLICE_MIN = 8'h01;
    localparam logic [7:0] SC_SLICE_MAX = 8'hAF;
    localparam logic [7:0] SC_SEQ_END   = 8'hB7;

    localparam logic [2:0] PT_P = 3'd2;
    localparam logic [2:0] PT_B = 3'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic       burst;
        logic [2:0] kind;
        logic [11:0] width;
        logic [11:0] height;
        logic [2:0] ptype;
        logic [4:0] qscale;
        logic [5:0] index;
        logic [7:0] value;
    } job_t;

    localparam logic [5:0] SCAN_ORDER [64] = '{
        6'd0, 6'd1, 6'd8, 6'd16, 6'd9, 6'd2, 6'd3, 6'd10,
        6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4, 6'd5,
        6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
        6'd27, 6'd20, 6'd13, 6'd6, 6'd7, 6'd14, 6'd21, 6'd28,
        6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
        6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
        6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
        6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
    };

    localparam logic [7:0] INTRA_DEFAULT [64] = '{
        8'd8, 8'd16, 8'd19, 8'd22, 8'd26, 8'd27, 8'd29, 8'd34,
        8'd16, 8'd16, 8'd22, 8'd24, 8'd27, 8'd29, 8'd34, 8'd37,
        8'd19, 8'd22, 8'd26, 8'd27, 8'd29, 8'd34, 8'd34, 8'd38,
        8'd22, 8'd22, 8'd26, 8'd27, 8'd29, 8'd34, 8'd37, 8'd40,
        8'd22, 8'd26, 8'd27, 8'd29, 8'd32, 8'd35, 8'd40, 8'd48,
        8'd26, 8'd27, 8'd29, 8'd32, 8'd35, 8'd40, 8'd48, 8'd58,
        8'd26, 8'd27, 8'd29, 8'd34, 8'd38, 8'd46, 8'd56, 8'd69,
        8'd27, 8'd29, 8'd35, 8'd38, 8'd46, 8'd56, 8'd69, 8'd83
    };

endpackage

`default_nettype wire

// File: src/mvhp_front.sv
// ----------------------------------------------------------------------------
// MPEG-1 header parser front end
// Takes one stream byte per beat, walks its eight bits through the header
// fields and hands at most one job per byte to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mvhp_front
    import mvhp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] data_byte,
    output job_t            job,
    output logic            push
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  zero_run_reg, zero_run_next;
    logic [23:0] buf_reg, buf_next;
    logic [4:0]  held_reg, held_next;
    logic [9:0]  skip_reg, skip_next;
    logic [6:0]  entry_reg, entry_next;
    logic [11:0] width_reg, width_next;
    logic        emit;

    always_comb
    begin
        logic       bitv;
        logic [2:0] pt;
        phase_next     = phase_reg;
        zero_run_next  = zero_run_reg;
        buf_next       = buf_reg;
        held_next      = held_reg;
        skip_next      = skip_reg;
        entry_next     = entry_reg;
        width_next     = width_reg;
        emit           = 1'b0;
        job            = '0;
        bitv           = 1'b0;
        pt             = '0;
        if (phase_reg == PH_HUNT)
        begin
            if (data_byte == 8'd1 && zero_run_reg == 2'd2)
            begin
                phase_next    = PH_CODE;
                zero_run_next = '0;
            end
            else if (data_byte == 8'd0)
                zero_run_next = (zero_run_reg == 2'd2) ? 2'd2 : zero_run_reg + 2'd1;
            else
                zero_run_next = '0;
        end
        else if (phase_reg == PH_CODE)
        begin
            buf_next      = '0;
            held_next     = '0;
            zero_run_next = '0;
            if (data_byte == SC_SEQ_HDR)
                phase_next = PH_SIZES;
            else if (data_byte == SC_PICTURE)
                phase_next = PH_PIC;
            else if (data_byte >= SC_SLICE_MIN && data_byte <= SC_SLICE_MAX)
                phase_next = PH_SLICE;
            else
            begin
                if (data_byte == SC_SEQ_END)
                begin
                    emit     = 1'b1;
                    job.kind = EV_END;
                end
                phase_next = PH_HUNT;
            end
        end
        else
        begin
            for (int b = 7; b >= 0; b--)
            begin
                bitv = data_byte[b];
                unique case (phase_next)
                    PH_SIZES:
                    begin
                        buf_next  = {buf_next[22:0], bitv};
                        held_next = held_next + 5'd1;
                        if (held_next == 5'd12)
                            width_next = buf_next[11:0];
                        if (held_next >= 5'd24)
                        begin
                            emit       = 1'b1;
                            job        = '0;
                            job.kind   = EV_SIZES;
                            job.width  = width_next;
                            job.height = buf_next[11:0];
                            held_next  = '0;
                            buf_next   = '0;
                            skip_next  = 10'd38;
                            phase_next = PH_SSKIP;
                        end
                    end
                    PH_SSKIP, PH_NSKIP, PH_PSKIP, PH_XSKIP:
                    begin
                        if (skip_next != '0)
                            skip_next = skip_next - 10'd1;
                        if (skip_next == '0)
                        begin
                            if (phase_next == PH_SSKIP)
                                phase_next = PH_IFLAG;
                            else if (phase_next == PH_NSKIP)
                                phase_next = PH_DONE;
                            else
                                phase_next = PH_XFLAG;
                        end
                    end
                    PH_IFLAG:
                    begin
                        if (bitv)
                        begin
                            entry_next = '0;
                            held_next  = '0;
                            buf_next   = '0;
                            phase_next = PH_IMAT;
                        end
                        else
                        begin
                            emit       = 1'b1;
                            job        = '0;
                            job.burst  = 1'b1;
                            job.kind   = EV_MATRIX;
                            phase_next = PH_NFLAG;
                        end
                    end
                    PH_IMAT:
                    begin
                        buf_next  = {buf_next[22:0], bitv};
                        held_next = held_next + 5'd1;
                        if (held_next >= 5'd8)
                        begin
                            emit       = 1'b1;
                            job        = '0;
                            job.kind   = EV_MATRIX;
                            job.index  = SCAN_ORDER[entry_next[5:0]];
                            job.value  = buf_next[7:0];
                            held_next  = '0;
                            buf_next   = '0;
                            entry_next = entry_next + 7'd1;
                            if (entry_next >= 7'd64)
                                phase_next = PH_NFLAG;
                        end
                    end
                    PH_NFLAG:
                    begin
                        if (bitv)
                        begin
                            skip_next  = 10'd512;
                            phase_next = PH_NSKIP;
                        end
                        else
                            phase_next = PH_DONE;
                    end
                    PH_PIC:
                    begin
                        buf_next  = {buf_next[22:0], bitv};
                        held_next = held_next + 5'd1;
                        if (held_next >= 5'd13)
                        begin
                            pt        = buf_next[2:0];
                            emit      = 1'b1;
                            job       = '0;
                            job.kind  = EV_PIC;
                            job.ptype = pt;
                            held_next = '0;
                            buf_next  = '0;
                            if (pt == PT_P)
                                skip_next = 10'd20;
                            else if (pt == PT_B)
                                skip_next = 10'd24;
                            else
                                skip_next = 10'd16;
                            phase_next = PH_PSKIP;
                        end
                    end
                    PH_XFLAG:
                    begin
                        if (bitv)
                        begin
                            skip_next  = 10'd8;
                            phase_next = PH_XSKIP;
                        end
                        else
                            phase_next = PH_DONE;
                    end
                    PH_SLICE:
                    begin
                        buf_next  = {buf_next[22:0], bitv};
                        held_next = held_next + 5'd1;
                        if (held_next >= 5'd5)
                        begin
                            emit       = 1'b1;
                            job        = '0;
                            job.kind   = EV_SLICE;
                            job.qscale = buf_next[4:0];
                            held_next  = '0;
                            buf_next   = '0;
                            phase_next = PH_DONE;
                        end
                    end
                    default:
                        phase_next = PH_DONE;
                endcase
            end
            if (phase_next == PH_DONE)
            begin
                phase_next    = PH_HUNT;
                zero_run_next = '0;
                held_next     = '0;
                buf_next      = '0;
            end
        end
    end

    assign push = take && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            zero_run_reg <= '0;
            buf_reg      <= '0;
            held_reg     <= '0;
            skip_reg     <= '0;
            entry_reg    <= '0;
            width_reg    <= '0;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            zero_run_reg <= zero_run_next;
            buf_reg      <= buf_next;
            held_reg     <= held_next;
            skip_reg     <= skip_next;
            entry_reg    <= entry_next;
            width_reg    <= width_next;
        end
    end

endmodule

`default_nettype wire

// File: src/mvhp_queue.sv
// ----------------------------------------------------------------------------
// MPEG-1 header parser job queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mvhp_queue
    import mvhp_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  job_t      wr_job,
    input  wire logic pop,
    output job_t      rd_job,
    output logic      full,
    output logic      empty
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    job_t            slot_reg [Depth];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]     count_reg;

    assign full   = (count_reg == (AW+1)'(Depth));
    assign empty  = (count_reg == '0);
    assign rd_job = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(Depth - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(Depth - 1)) ? '0 : rd_ptr_reg + AW'(1);
            if (push && !pop)
                count_reg <= count_reg + (AW+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (AW+1)'(1);
        end
    end

endmodule

`default_nettype wire

// File: src/mvhp_back.sv
// ----------------------------------------------------------------------------
// MPEG-1 header parser back end
// Turns queued jobs into result beats held in an output register and
// expands a default-matrix job into 64 matrix entry beats.
// ----------------------------------------------------------------------------
`default_nettype none

module mvhp_back
    import mvhp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  job_t             head,
    input  wire logic        empty,
    output logic             pop,
    output logic             event_valid,
    input  wire logic        event_ready,
    output logic [2:0]       event_kind,
    output logic [11:0]      size_width,
    output logic [11:0]      size_height,
    output logic [2:0]       picture_type,
    output logic [4:0]       quant_scale,
    output logic [5:0]       matrix_index,
    output logic [7:0]       matrix_value,
    output logic             last_of_run
);

    logic        valid_reg;
    logic [5:0]  cnt_reg;
    job_t        out_reg;
    job_t        load_job;
    logic        last_reg;
    logic        load;
    logic        burst_end;

    assign load      = !empty && (!valid_reg || event_ready);
    assign burst_end = (cnt_reg == 6'd63);
    assign pop       = load && (!head.burst || burst_end);

    always_comb
    begin
        load_job = head;
        if (head.burst)
        begin
            load_job.index = cnt_reg;
            load_job.value = INTRA_DEFAULT[cnt_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (load)
                valid_reg <= 1'b1;
            else if (event_ready)
                valid_reg <= 1'b0;
            if (load && head.burst)
                cnt_reg <= cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg  <= load_job;
            last_reg <= !head.burst || burst_end;
        end
    end

    assign event_valid  = valid_reg;
    assign event_kind   = out_reg.kind;
    assign size_width   = out_reg.width;
    assign size_height  = out_reg.height;
    assign picture_type = out_reg.ptype;
    assign quant_scale  = out_reg.qscale;
    assign matrix_index = out_reg.index;
    assign matrix_value = out_reg.value;
    assign last_of_run  = last_reg;

endmodule

`default_nettype wire

// File: src/mpeg1_video_header_parser_core.sv
// ----------------------------------------------------------------------------
// MPEG-1 video header parser
// Finds start codes in a video elementary stream and reports header fields.
// ----------------------------------------------------------------------------
// The data channel takes one stream byte per beat, most significant bit first.
// The event channel gives one beat per reported item: picture sizes, picture
// type, slice quantiser scale, sequence end, or an intra matrix entry.
// last_of_run marks the final beat caused by one input byte.
// A byte is taken every cycle while the two-entry job queue has room.
// A job enters the queue at the edge that accepts its byte and moves into the
// output register once that register is free or its beat is being taken.
// A default intra matrix comes out as 64 beats from the back end's table counter,
// one per cycle while the receiver accepts; bytes keep flowing in until the queue fills.
// When the receiver stalls, the output register holds its beat, the queue
// fills and data_ready drops.
// Reset returns the parser to start code hunting with the queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module mpeg1_video_header_parser_core
    import mvhp_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        data_valid,
    output logic             data_ready,
    input  wire logic [7:0]  data_byte,
    output logic             event_valid,
    input  wire logic        event_ready,
    output logic [2:0]       event_kind,
    output logic [11:0]      size_width,
    output logic [11:0]      size_height,
    output logic [2:0]       picture_type,
    output logic [4:0]       quant_scale,
    output logic [5:0]       matrix_index,
    output logic [7:0]       matrix_value,
    output logic             last_of_run
);

    job_t new_job, head_job;
    logic push, pop, full, empty, take;

    assign data_ready = !full;
    assign take       = data_valid && data_ready;

    mvhp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .job       (new_job),
        .push      (push)
    );

    mvhp_queue #(.Depth(QueueDepth)) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (new_job),
        .pop    (pop),
        .rd_job (head_job),
        .full   (full),
        .empty  (empty)
    );

    mvhp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_job),
        .empty        (empty),
        .pop          (pop),
        .event_valid  (event_valid),
        .event_ready  (event_ready),
        .event_kind   (event_kind),
        .size_width   (size_width),
        .size_height  (size_height),
        .picture_type (picture_type),
        .quant_scale  (quant_scale),
        .matrix_index (matrix_index),
        .matrix_value (matrix_value),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire

// File: src/mvhp_checker.sv
// ----------------------------------------------------------------------------
// MPEG-1 header parser checker
// Port-level checks on the event channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mpeg1_video_header_parser_core_defines.svh"

module mvhp_checker
    import mvhp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        event_valid,
    input wire logic        event_ready,
    input wire logic [2:0]  event_kind,
    input wire logic [5:0]  matrix_index,
    input wire logic [7:0]  matrix_value,
    input wire logic        last_of_run
);

    `MVHP_ASSERT_NEXT(a_hold, event_valid && !event_ready,
        event_valid && $stable(event_kind) && $stable(matrix_index) && $stable(matrix_value))
    `MVHP_ASSERT_NOW(a_kind_range, event_valid, event_kind <= EV_END)
    `MVHP_ASSERT_NOW(a_matrix_clean, event_valid && event_kind != EV_MATRIX,
        matrix_index == 6'd0 && matrix_value == 8'd0)
    `MVHP_ASSERT_NOW(a_single_last, event_valid && event_kind != EV_MATRIX, last_of_run)

endmodule

bind mpeg1_video_header_parser_core mvhp_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .event_valid  (event_valid),
    .event_ready  (event_ready),
    .event_kind   (event_kind),
    .matrix_index (matrix_index),
    .matrix_value (matrix_value),
    .last_of_run  (last_of_run)
);

`default_nettype wire
